FILE: src/tfla_pkg.sv
`default_nettype none

package tfla_pkg;

    // Pool size and derived widths
    localparam int TIMER_COUNT = 64;
    localparam int IDX_W       = $clog2(TIMER_COUNT);
    localparam int CNT_W       = $clog2(TIMER_COUNT + 1);

    // Port field widths
    localparam int RID_W  = 8;
    localparam int GID_W  = 6;
    localparam int FREE_W = 7;

    // Request codes
    typedef enum logic {
        FUNC_RESERVE = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_EMPTY        = 2'd1,
        STAT_RANGE        = 2'd2,
        STAT_NOT_RESERVED = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Write port of the free ring
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] data;
    } ring_wr_t;

    // Write port of the reserved marks
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic             data;
    } mark_wr_t;

endpackage

`default_nettype wire

FILE: src/tfla_ring.sv
`default_nettype none

// Free ring: one write port, one registered read port.
// An entry never written reads as its own index.
module tfla_ring
    import tfla_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [IDX_W-1:0] rd_data,
    input  wire ring_wr_t         wr
);

    logic [IDX_W-1:0]       mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] valid_reg;
    logic [IDX_W-1:0]       q_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic                   hit_reg;

    // Storage and read data
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            q_reg    <= mem[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    // Written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? q_reg : addr_reg;

endmodule

`default_nettype wire

FILE: src/tfla_mark.sv
`default_nettype none

// Reserved marks: one write port, one registered read port.
// An entry never written reads as clear.
module tfla_mark
    import tfla_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic                  rd_data,
    input  wire mark_wr_t         wr
);

    logic                   mem [TIMER_COUNT];
    logic [TIMER_COUNT-1:0] valid_reg;
    logic                   q_reg;
    logic                   hit_reg;

    // Storage and read data
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // Written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg & q_reg;

endmodule

`default_nettype wire

FILE: src/timer_id_free_list_allocator.sv
// Channel   Handshake           Beat fields
// -------   -----------------   ---------------------------------
// request   start / busy        func, release_id
// result    done (one cycle)    granted_id, status, free_left
//
// In each request, the accept cycle issues reads of the free
// ring and the reserved marks, the next cycle checks and writes back.
// The result strobe comes in the cycle after that, and busy is already low
// then, so a new request can be taken while the result is shown; no request
// is taken while busy, as the memories have a registered read.
// Reset: pool full, ring holds 0..63 in order, no identifier reserved.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module timer_id_free_list_allocator
    import tfla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              func,
    input  wire logic [RID_W-1:0]  release_id,
    output logic                   done,
    output logic      [GID_W-1:0]  granted_id,
    output logic      [1:0]        status,
    output logic      [FREE_W-1:0] free_left
);

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   take_reg;
    logic [IDX_W-1:0]   take_next;
    logic [IDX_W-1:0]   return_reg;
    logic [IDX_W-1:0]   return_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    func_t              func_reg;
    logic [RID_W-1:0]   rid_reg;
    logic               done_reg;
    logic               done_next;
    logic [GID_W-1:0]   gid_reg;
    logic [GID_W-1:0]   gid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [FREE_W-1:0]  free_reg;

    logic               accept;
    logic               exec;
    logic [IDX_W-1:0]   ring_q;
    logic               mark_q;
    logic               rid_in_range;
    ring_wr_t           ring_wr;
    mark_wr_t           mark_wr;

    // State memories
    tfla_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (take_reg),
        .rd_data (ring_q),
        .wr      (ring_wr)
    );

    tfla_mark u_mark (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (IDX_W'(release_id)),
        .rd_data (mark_q),
        .wr      (mark_wr)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        busy = 1'b0;
        exec = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign accept       = start & ~busy;
    assign rid_in_range = 32'(rid_reg) < TIMER_COUNT;

    // Check and write back
    always_comb
    begin
        take_next   = take_reg;
        return_next = return_reg;
        count_next  = count_reg;
        done_next   = exec;
        gid_next    = '0;
        status_next = STAT_OK;
        ring_wr     = '0;
        mark_wr     = '0;
        if (exec)
        begin
            if (func_reg == FUNC_RESERVE)
            begin
                if (count_reg == '0)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    gid_next     = GID_W'(ring_q);
                    mark_wr.en   = 1'b1;
                    mark_wr.addr = ring_q;
                    mark_wr.data = 1'b1;
                    take_next    = (32'(take_reg) == TIMER_COUNT - 1) ? '0 : take_reg + 1'b1;
                    count_next   = count_reg - 1'b1;
                end
            end
            else if (!rid_in_range)
            begin
                status_next = STAT_RANGE;
            end
            else if (!mark_q || count_reg >= CNT_W'(TIMER_COUNT))
            begin
                status_next = STAT_NOT_RESERVED;
            end
            else
            begin
                mark_wr.en   = 1'b1;
                mark_wr.addr = IDX_W'(rid_reg);
                mark_wr.data = 1'b0;
                ring_wr.en   = 1'b1;
                ring_wr.addr = return_reg;
                ring_wr.data = IDX_W'(rid_reg);
                return_next  = (32'(return_reg) == TIMER_COUNT - 1) ? '0 : return_reg + 1'b1;
                count_next   = count_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            take_reg   <= '0;
            return_reg <= '0;
            count_reg  <= CNT_W'(TIMER_COUNT);
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            take_reg   <= take_next;
            return_reg <= return_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    // Request capture and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            rid_reg  <= release_id;
        end
        if (exec)
        begin
            gid_reg    <= gid_next;
            status_reg <= status_next;
            free_reg   <= FREE_W'(count_next);
        end
    end

    assign done       = done_reg;
    assign granted_id = gid_reg;
    assign status     = status_reg;
    assign free_left  = free_reg;

endmodule

`default_nettype wire

FILE: src/tfla_checker.sv
`default_nettype none

module tfla_checker
    import tfla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              done,
    input  wire logic [GID_W-1:0]  granted_id,
    input  wire logic [1:0]        status,
    input  wire logic [FREE_W-1:0] free_left
);

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // Busy lasts one cycle and ends with a result beat
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("busy cycle not followed by a result beat");

    // A result beat only follows a busy cycle
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a request");

    // Failed results hand out no identifier; a release result carries zero as well
    a_gid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_OK) |-> (granted_id == '0))
        else $error("identifier shown on a failed request");

    // Empty pool reports zero free
    a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EMPTY) |-> (free_left == '0))
        else $error("pool empty with identifiers left");

endmodule

bind timer_id_free_list_allocator tfla_checker u_tfla_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .granted_id (granted_id),
    .status     (status),
    .free_left  (free_left)
);

`default_nettype wire
